// File: sv/fern_posterior_classifier_top_defines.svh
// ----------------------------------------------------------------------------
// fern posterior classifier assertion macros
// concurrent check wrappers, removed for synthesis
// ----------------------------------------------------------------------------
`ifndef FERN_POSTERIOR_CLASSIFIER_TOP_DEFINES_SVH
`define FERN_POSTERIOR_CLASSIFIER_TOP_DEFINES_SVH
`ifndef SYNTHESIS
`define FPC_ASSERT(lbl, prop) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error("fpc assertion failed");
`define FPC_ASSERT_ALWAYS(lbl, prop) \
	lbl: assert property (@(posedge clk) prop) else $error("fpc assertion failed");
`else
`define FPC_ASSERT(lbl, prop)
`define FPC_ASSERT_ALWAYS(lbl, prop)
`endif
`endif

// File: sv/fpc_pkg.sv
// ----------------------------------------------------------------------------
// fpc_pkg
// shared constants, payload and control types of the fern classifier
// ----------------------------------------------------------------------------
package fpc_pkg;
	localparam int TREE_COUNT  = 10;
	localparam int LEAF_BITS   = 13;
	localparam int TREE_W      = (TREE_COUNT > 1) ? $clog2(TREE_COUNT) : 1;
	localparam int ADDR_W      = TREE_W + LEAF_BITS;
	localparam int TABLE_DEPTH = TREE_COUNT << LEAF_BITS;
	localparam int VOTE_W      = 20;
	localparam int CNT_W       = 16;
	localparam int POST_W      = 17;
	localparam int THR_W       = 17;
	localparam int POS_W       = 5;
	localparam int LIM_W       = 22;
	localparam int DIV_STEPS   = 17;
	localparam int STEP_W      = 5;
	localparam logic [POS_W-1:0]  POS_MAX    = 5'd31;
	localparam logic [THR_W-1:0]  THR_RESET  = 17'd39322;
	localparam logic [LIM_W-1:0]  NEG_LIMIT  = LIM_W'(TREE_COUNT * 32768);
	localparam logic [VOTE_W-1:0] VOTE_MAX   = '1;
	localparam logic [CNT_W-1:0]  COUNT_MAX  = '1;

	typedef struct packed {
		logic        cmd;
		logic        label;
		logic [12:0] leaf_index;
		logic        last_leaf;
	} sample_t;

	typedef struct packed {
		logic [VOTE_W-1:0] vote_sum;
		logic              was_updated;
		logic              count_error;
	} result_t;

	typedef struct packed {
		logic [POST_W-1:0] post;
		logic [CNT_W-1:0]  pos;
		logic [CNT_W-1:0]  neg;
	} entry_t;

	typedef struct packed {
		logic clr;
		logic accept;
		logic acc;
		logic push;
		logic trn_start;
		logic trn_rd;
		logic trn_load;
		logic trn_wr;
	} fpc_cmd_t;

	typedef struct packed {
		logic clr_done;
		logic last_q;
		logic out_free;
		logic trn_go;
		logic div_busy;
		logic trn_end;
	} fpc_sts_t;
endpackage

// File: sv/fern_posterior_classifier_top.sv
// ----------------------------------------------------------------------------
// fern_posterior_classifier_top
// random ferns classifier: posterior vote per sample with online training
// ----------------------------------------------------------------------------
// After reset the posterior and counter tables are cleared one entry a cycle,
// all 81920 entries, while no sample transaction is taken. Each leaf then
// goes through a memory read and an accumulate step, and the closing leaf through
// a further decide step that hands the vote to the result register once it is
// free. A training update walks the 10 trees through the table and the serial
// divider before the next leaf is taken.
module fern_posterior_classifier_top (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          sample_valid,
	output logic                          sample_stall,
	input  fpc_pkg::sample_t              sample,
	output logic                          result_valid,
	input  logic                          result_stall,
	output fpc_pkg::result_t              result,
	input  logic                          thr_we,
	input  logic [fpc_pkg::THR_W-1:0]     thr_wdata
);
	fpc_pkg::fpc_cmd_t cmd;
	fpc_pkg::fpc_sts_t sts;

	fpc_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.sample_valid (sample_valid),
		.sample_stall (sample_stall),
		.cmd          (cmd),
		.sts          (sts)
	);

	fpc_dpath u_dpath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.sts          (sts),
		.sample       (sample),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result),
		.thr_we       (thr_we),
		.thr_wdata    (thr_wdata)
	);
endmodule

// File: sv/fpc_div.sv
// ----------------------------------------------------------------------------
// fpc_div
// restoring divider, one quotient bit per cycle: p * 65536 / (p + n)
// ----------------------------------------------------------------------------
module fpc_div (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	input  logic [fpc_pkg::CNT_W-1:0]         p,
	input  logic [fpc_pkg::CNT_W-1:0]         n,
	output logic                              busy,
	output logic [fpc_pkg::POST_W-1:0]        quot
);
	logic                              busy_q;
	logic [fpc_pkg::STEP_W-1:0]        cnt_q;
	logic [fpc_pkg::POST_W-1:0]        rem_q;
	logic [fpc_pkg::POST_W-1:0]        den_q;
	logic [fpc_pkg::POST_W-1:0]        quot_q;
	logic                              bit0_q;
	logic [fpc_pkg::POST_W:0]          trial;
	logic                              fits;

	assign trial = {rem_q, (cnt_q == fpc_pkg::STEP_W'(fpc_pkg::DIV_STEPS)) ? bit0_q : 1'b0};
	assign fits  = trial >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= fpc_pkg::STEP_W'(fpc_pkg::DIV_STEPS);
		end else if (busy_q) begin
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == fpc_pkg::STEP_W'(1))
				busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q  <= fpc_pkg::POST_W'(p >> 1);
			den_q  <= fpc_pkg::POST_W'(p) + fpc_pkg::POST_W'(n);
			bit0_q <= p[0];
			quot_q <= '0;
		end else if (busy_q) begin
			rem_q  <= fits ? fpc_pkg::POST_W'(trial - {1'b0, den_q}) : trial[fpc_pkg::POST_W-1:0];
			quot_q <= {quot_q[fpc_pkg::POST_W-2:0], fits};
		end
	end

	assign busy = busy_q;
	assign quot = quot_q;
endmodule

// File: sv/fpc_dpath.sv
// ----------------------------------------------------------------------------
// fpc_dpath
// posterior and counter memory, vote accumulator, leaf buffer and result register
// ----------------------------------------------------------------------------
module fpc_dpath (
	input  logic                          clk,
	input  logic                          arst_n,
	input  fpc_pkg::fpc_cmd_t             cmd,
	output fpc_pkg::fpc_sts_t             sts,
	input  fpc_pkg::sample_t              sample,
	output logic                          result_valid,
	input  logic                          result_stall,
	output fpc_pkg::result_t              result,
	input  logic                          thr_we,
	input  logic [fpc_pkg::THR_W-1:0]     thr_wdata
);
	fpc_pkg::entry_t                   mem [fpc_pkg::TABLE_DEPTH];
	fpc_pkg::entry_t                   rdata_q;
	fpc_pkg::entry_t                   wdata;
	logic [fpc_pkg::ADDR_W-1:0]        raddr;
	logic [fpc_pkg::ADDR_W-1:0]        waddr;
	logic                              we;
	logic [fpc_pkg::LEAF_BITS-1:0]     lbuf_q [fpc_pkg::TREE_COUNT];
	logic [fpc_pkg::LEAF_BITS-1:0]     leaf;
	logic [fpc_pkg::ADDR_W-1:0]        clr_cnt_q;
	logic [fpc_pkg::ADDR_W-1:0]        trn_addr_q;
	logic [fpc_pkg::TREE_W-1:0]        tidx_q;
	logic [fpc_pkg::POS_W-1:0]         tpos_q;
	logic [fpc_pkg::VOTE_W-1:0]        acc_q;
	logic [fpc_pkg::VOTE_W:0]          sum;
	logic [fpc_pkg::THR_W-1:0]         thr_q;
	logic [fpc_pkg::LIM_W-1:0]         pos_lim;
	logic                              hit_q, last_q, train_q, label_q, err_q;
	logic [fpc_pkg::CNT_W-1:0]         p_nx, n_nx, p_q, n_q;
	logic                              div_busy;
	logic [fpc_pkg::POST_W-1:0]        quot;
	logic                              res_valid_q;
	fpc_pkg::result_t                  res_q;
	logic                              go;

	assign leaf    = fpc_pkg::LEAF_BITS'(sample.leaf_index);
	assign raddr   = cmd.trn_rd ? {tidx_q, lbuf_q[tidx_q]}
	                            : {tpos_q[fpc_pkg::TREE_W-1:0], leaf};
	assign we      = cmd.clr | cmd.trn_wr;
	assign waddr   = cmd.clr ? clr_cnt_q : trn_addr_q;
	assign wdata   = cmd.clr ? '0
	                         : {(p_q == '0) ? fpc_pkg::POST_W'(0) : quot, p_q, n_q};

	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
		rdata_q <= mem[raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q <= fpc_pkg::THR_RESET;
		end else if (thr_we) begin
			thr_q <= thr_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_cnt_q <= '0;
		end else if (cmd.clr) begin
			clr_cnt_q <= clr_cnt_q + 1'b1;
		end
	end

	// sample capture and tree position
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tpos_q  <= '0;
			acc_q   <= '0;
			last_q  <= 1'b0;
		end else begin
			if (cmd.accept) begin
				last_q <= sample.last_leaf;
				if (sample.last_leaf)
					tpos_q <= '0;
				else if (tpos_q != fpc_pkg::POS_MAX)
					tpos_q <= tpos_q + 1'b1;
			end
			if (cmd.acc && hit_q)
				acc_q <= sum[fpc_pkg::VOTE_W] ? fpc_pkg::VOTE_MAX : sum[fpc_pkg::VOTE_W-1:0];
			if (cmd.push)
				acc_q <= '0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			hit_q   <= tpos_q < fpc_pkg::POS_W'(fpc_pkg::TREE_COUNT);
			train_q <= sample.cmd;
			label_q <= sample.label;
			err_q   <= (tpos_q + 1'b1) != fpc_pkg::POS_W'(fpc_pkg::TREE_COUNT);
			if (tpos_q < fpc_pkg::POS_W'(fpc_pkg::TREE_COUNT))
				lbuf_q[tpos_q[fpc_pkg::TREE_W-1:0]] <= leaf;
		end
	end

	assign sum     = {1'b0, acc_q} + fpc_pkg::VOTE_W'(rdata_q.post);
	assign pos_lim = fpc_pkg::LIM_W'(thr_q) * fpc_pkg::LIM_W'(fpc_pkg::TREE_COUNT);
	assign go      = !err_q && train_q &&
	                 (label_q ? (fpc_pkg::LIM_W'(acc_q) <= pos_lim)
	                          : (fpc_pkg::LIM_W'(acc_q) >= fpc_pkg::NEG_LIMIT));

	// training walk over the stored leaves
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tidx_q <= '0;
		end else if (cmd.trn_start) begin
			tidx_q <= '0;
		end else if (cmd.trn_wr) begin
			tidx_q <= tidx_q + 1'b1;
		end
	end

	assign p_nx = (label_q && rdata_q.pos != fpc_pkg::COUNT_MAX) ? rdata_q.pos + 1'b1 : rdata_q.pos;
	assign n_nx = (!label_q && rdata_q.neg != fpc_pkg::COUNT_MAX) ? rdata_q.neg + 1'b1 : rdata_q.neg;

	always_ff @(posedge clk) begin
		if (cmd.trn_rd)
			trn_addr_q <= raddr;
		if (cmd.trn_load) begin
			p_q <= p_nx;
			n_q <= n_nx;
		end
	end

	fpc_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cmd.trn_load),
		.p      (p_nx),
		.n      (n_nx),
		.busy   (div_busy),
		.quot   (quot)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (cmd.push) begin
			res_valid_q <= 1'b1;
		end else if (!result_stall) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.push)
			res_q <= {acc_q, go, err_q};
	end

	assign result_valid = res_valid_q;
	assign result       = res_q;

	assign sts.clr_done = clr_cnt_q == fpc_pkg::ADDR_W'(fpc_pkg::TABLE_DEPTH - 1);
	assign sts.last_q   = last_q;
	assign sts.out_free = !res_valid_q || !result_stall;
	assign sts.trn_go   = go;
	assign sts.div_busy = div_busy;
	assign sts.trn_end  = tidx_q == fpc_pkg::TREE_W'(fpc_pkg::TREE_COUNT - 1);
endmodule

// File: sv/fpc_ctrl.sv
// ----------------------------------------------------------------------------
// fpc_ctrl
// sequencer for table clearing, vote accumulation and training updates
// ----------------------------------------------------------------------------
`include "fern_posterior_classifier_top_defines.svh"
module fpc_ctrl (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  sample_valid,
	output logic                  sample_stall,
	output fpc_pkg::fpc_cmd_t     cmd,
	input  fpc_pkg::fpc_sts_t     sts
);
	typedef enum logic [7:0] {
		S_CLEAR  = 8'b0000_0001,
		S_IDLE   = 8'b0000_0010,
		S_ACC    = 8'b0000_0100,
		S_DECIDE = 8'b0000_1000,
		S_TRD    = 8'b0001_0000,
		S_TLOAD  = 8'b0010_0000,
		S_TDIV   = 8'b0100_0000,
		S_TWR    = 8'b1000_0000
	} state_t;

	state_t state_q, state_nx;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
		end else begin
			state_q <= state_nx;
		end
	end

	always_comb begin
		state_nx = state_q;
		cmd      = '0;
		unique case (state_q)
			S_CLEAR: begin
				cmd.clr = 1'b1;
				if (sts.clr_done)
					state_nx = S_IDLE;
			end
			S_IDLE: begin
				if (sample_valid) begin
					cmd.accept = 1'b1;
					state_nx   = S_ACC;
				end
			end
			S_ACC: begin
				cmd.acc  = 1'b1;
				state_nx = sts.last_q ? S_DECIDE : S_IDLE;
			end
			S_DECIDE: begin
				if (sts.out_free) begin
					cmd.push = 1'b1;
					if (sts.trn_go) begin
						cmd.trn_start = 1'b1;
						state_nx      = S_TRD;
					end else begin
						state_nx = S_IDLE;
					end
				end
			end
			S_TRD: begin
				cmd.trn_rd = 1'b1;
				state_nx   = S_TLOAD;
			end
			S_TLOAD: begin
				cmd.trn_load = 1'b1;
				state_nx     = S_TDIV;
			end
			S_TDIV: begin
				if (!sts.div_busy)
					state_nx = S_TWR;
			end
			S_TWR: begin
				cmd.trn_wr = 1'b1;
				state_nx   = sts.trn_end ? S_IDLE : S_TRD;
			end
			default: begin
				state_nx = S_CLEAR;
			end
		endcase
	end

	assign sample_stall = state_q != S_IDLE;

	`FPC_ASSERT(a_state_onehot, $onehot(state_q))
	`FPC_ASSERT(a_accept_to_acc, (sample_valid && !sample_stall) |=> state_q == S_ACC)
	`FPC_ASSERT(a_wr_after_div, cmd.trn_wr |-> $past(state_q) == S_TDIV)
	`FPC_ASSERT(a_push_only_free, cmd.push |-> sts.out_free)
endmodule
